// ===== sv/udiv256_pkg.sv =====
// Shared types, constants and the control program for the 256-bit divider.
package udiv256_pkg;

    localparam int WORD_BITS       = 64;
    localparam int NUM_WORDS       = 4;
    localparam int MAX_BITS        = WORD_BITS * NUM_WORDS;
    localparam int DEF_VALUE_BYTES = 32;

    typedef logic [WORD_BITS-1:0] word_t;

    // Program counter; the last step falls through to the first.
    typedef enum logic [1:0] {
        PC_IDLE,
        PC_CHECK,
        PC_ITER,
        PC_PUBLISH
    } pc_t;

    // Branch condition of a control word; the branch is taken when it holds.
    typedef enum logic [1:0] {
        JMP_NO_INPUT,
        JMP_DIV_ZERO,
        JMP_CNT_NZ,
        JMP_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  accept;      // open the input channel, load operands
        logic  check_zero;  // capture the zero-divisor flag
        logic  step;        // one shift-subtract iteration
        logic  publish;     // move the result into the output register
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t cw;
        cw = '0;
        unique case (pc)
            PC_IDLE:
            begin
                cw.accept = 1'b1;
                cw.cond   = JMP_NO_INPUT;
                cw.target = PC_IDLE;
            end
            PC_CHECK:
            begin
                cw.check_zero = 1'b1;
                cw.cond       = JMP_DIV_ZERO;
                cw.target     = PC_PUBLISH;
            end
            PC_ITER:
            begin
                cw.step   = 1'b1;
                cw.cond   = JMP_CNT_NZ;
                cw.target = PC_ITER;
            end
            PC_PUBLISH:
            begin
                cw.publish = 1'b1;
                cw.cond    = JMP_OUT_BUSY;
                cw.target  = PC_PUBLISH;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== sv/unsigned_divider_256.sv =====
// Unsigned restoring divider, quotient only, run by a microcoded sequencer.
//
// Usage: present a dividend and a divisor (four 64-bit words each, least
// significant word first) on the input channel with in_valid; the word is
// taken at a clock edge where in_valid is high and in_stall is low. The
// quotient words and divide_by_zero come out on the output channel and are
// taken at an edge where out_valid is high and out_stall is low.
// Only the low VALUE_BYTES*8 bits of each operand take part; quotient bits
// above that width read zero. A zero divisor raises divide_by_zero and
// gives a zero quotient.
// Sequence: a control ROM steps through accept, zero check, one iteration
// per quotient bit on a single wide compare/subtract unit, then publish.
// A zero divisor branches from the zero check straight to publish and
// skips the iterations. One division is in flight at a time; the next
// word is accepted on the cycle after publish, so a new division starts
// only once the last one has been published.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any pending result. When the receiver stalls, the result holds in the
// output register and the sequencer waits in publish only if a second
// result is ready before the first is taken.
module unsigned_divider_256
    #(
        parameter int VALUE_BYTES = udiv256_pkg::DEF_VALUE_BYTES
    )
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               in_valid,
        output logic               in_stall,
        input  udiv256_pkg::word_t dividend_w0,
        input  udiv256_pkg::word_t dividend_w1,
        input  udiv256_pkg::word_t dividend_w2,
        input  udiv256_pkg::word_t dividend_w3,
        input  udiv256_pkg::word_t divisor_w0,
        input  udiv256_pkg::word_t divisor_w1,
        input  udiv256_pkg::word_t divisor_w2,
        input  udiv256_pkg::word_t divisor_w3,
        output logic               out_valid,
        input  logic               out_stall,
        output udiv256_pkg::word_t quotient_w0,
        output udiv256_pkg::word_t quotient_w1,
        output udiv256_pkg::word_t quotient_w2,
        output udiv256_pkg::word_t quotient_w3,
        output logic               divide_by_zero
    );

    import udiv256_pkg::*;

    localparam int VB    = VALUE_BYTES * 8;
    localparam int CNT_W = $clog2(VB);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VB - 1);

    // Sequencer state
    pc_t              pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath: the dividend register shifts out at the top while quotient
    // bits shift in at the bottom, so it ends up holding the quotient.
    logic [VB-1:0]       num_reg, num_next;
    logic [VB-1:0]       div_reg, div_next;
    logic [VB-1:0]       rem_reg, rem_next;
    logic                dbz_reg, dbz_next;
    logic [MAX_BITS-1:0] quo_reg, quo_next;
    logic                quo_dbz_reg, quo_dbz_next;

    ctrl_t               cw;
    logic                take;
    logic                jump;
    logic                out_free;
    logic                div_zero;
    logic [MAX_BITS-1:0] dvd_full, dsr_full;
    logic [VB:0]         rem_shift;
    logic [VB:0]         diff;

    assign cw       = ucode_rom(pc_reg);
    assign in_stall = !cw.accept;
    assign take     = cw.accept && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign div_zero = (div_reg == '0);

    assign dvd_full = {dividend_w3, dividend_w2, dividend_w1, dividend_w0};
    assign dsr_full = {divisor_w3, divisor_w2, divisor_w1, divisor_w0};

    // Bring down the next dividend bit and trial-subtract the divisor.
    assign rem_shift = {rem_reg, num_reg[VB-1]};
    assign diff      = rem_shift - {1'b0, div_reg};

    always_comb
    begin
        unique case (cw.cond)
            JMP_NO_INPUT: jump = !in_valid;
            JMP_DIV_ZERO: jump = div_zero;
            JMP_CNT_NZ:   jump = (cnt_reg != '0);
            JMP_OUT_BUSY: jump = !out_free;
        endcase
    end

    always_comb
    begin
        pc_next        = jump ? cw.target : pc_t'(pc_reg + 2'd1);
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        dbz_next       = dbz_reg;
        quo_next       = quo_reg;
        quo_dbz_next   = quo_dbz_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (take)
        begin
            num_next = dvd_full[VB-1:0];
            div_next = dsr_full[VB-1:0];
            rem_next = '0;
            cnt_next = CNT_LAST;
        end

        if (cw.check_zero)
        begin
            dbz_next = div_zero;
        end

        if (cw.step)
        begin
            if (!diff[VB])
            begin
                rem_next = diff[VB-1:0];
            end
            else
            begin
                rem_next = rem_shift[VB-1:0];
            end
            num_next = {num_reg[VB-2:0], !diff[VB]};
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end

        if (cw.publish && out_free)
        begin
            quo_next = '0;
            if (!dbz_reg)
            begin
                quo_next[VB-1:0] = num_reg;
            end
            quo_dbz_next   = dbz_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            dbz_reg       <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            dbz_reg       <= dbz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        quo_dbz_reg <= quo_dbz_next;
    end

    assign out_valid      = out_valid_reg;
    assign quotient_w0    = quo_reg[WORD_BITS-1:0];
    assign quotient_w1    = quo_reg[2*WORD_BITS-1:WORD_BITS];
    assign quotient_w2    = quo_reg[3*WORD_BITS-1:2*WORD_BITS];
    assign quotient_w3    = quo_reg[4*WORD_BITS-1:3*WORD_BITS];
    assign divide_by_zero = quo_dbz_reg;

    // A new result appears only from the publish step.
    a_rise_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg == PC_PUBLISH))
        else $error("result raised outside publish step");

    // A zero-divisor result carries a zero quotient.
    a_dbz_zero_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && quo_dbz_reg) |-> (quo_reg == '0))
        else $error("nonzero quotient with divide_by_zero");

    // The partial remainder stays below the divisor throughout the iterations.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_ITER) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    // The bit counter is loaded with CNT_LAST (VB - 1) for every new division.
    a_cnt_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_CHECK) |-> (cnt_reg == CNT_LAST))
        else $error("bit counter not loaded at check step");

endmodule
